/* sv/hbfs_pkg.sv */
// Package for the heartbeat fault supervisor: word types, event codes,
// register indexes and the constants of the seconds conversion.
// No dependencies.
package hbfs_pkg;

    // Event kinds carried in the mode field.
    localparam logic [2:0] MODE_CHECK     = 3'd0;
    localparam logic [2:0] MODE_HEARTBEAT = 3'd1;
    localparam logic [2:0] MODE_CRC_ERR   = 3'd2;
    localparam logic [2:0] MODE_AUTH_FAIL = 3'd3;
    localparam logic [2:0] MODE_FAULT     = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_SAFE_TIMEOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_TIMEOUT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_LIMIT         = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTH_LIMIT        = 8'd3;

    // Register reset values.
    localparam logic [31:0] FAIL_SAFE_TIMEOUT_RST = 32'd5000;
    localparam logic [31:0] DEGRADED_TIMEOUT_RST  = 32'd2000;
    localparam logic [7:0]  CRC_LIMIT_RST         = 8'd10;
    localparam logic [7:0]  AUTH_LIMIT_RST        = 8'd3;

    // Milliseconds to whole seconds, saturating at MISSED_MAX. Below the
    // saturation point elapsed fits in ELAPSED_W bits, and a multiply by a
    // rounded-up reciprocal gives the exact quotient over that range.
    localparam int unsigned MS_PER_SECOND = 1000;
    localparam logic [7:0]  MISSED_MAX    = 8'd255;
    localparam logic [31:0] SAT_ELAPSED   = 32'd255000;
    localparam int unsigned ELAPSED_W     = 18;
    localparam int unsigned RECIP_SHIFT   = 28;
    localparam int unsigned RECIP_W       = 19;
    localparam logic [RECIP_W-1:0] RECIP  =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + MS_PER_SECOND - 1) / MS_PER_SECOND);
    localparam int unsigned PROD_W        = ELAPSED_W + RECIP_W;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
    } t_event;

    typedef struct packed {
        logic       fail_safe_active;
        logic       degraded_mode;
        logic [7:0] missed_seconds;
    } t_status;

endpackage

/* sv/heartbeat_fault_supervisor_unit.sv */
// Top level of the heartbeat fault supervisor: input register, event update
// logic, supervisor state, configuration registers and result register.
// Depends on hbfs_pkg.

// The supervisor takes one event word per clock cycle while it does not
// raise o_stall and returns one status word for each event, in order. An
// accepted event is held in the input register. The update logic then
// applies it to the supervisor state and loads the resulting status into
// the output register, from which the status word is presented; a stall on
// the output can hold an event in the input register in between. With no
// stall on the output the sustained rate is one event per cycle. The update
// stage is the only place where state changes, so each event sees the state
// left by the one before it. The configuration port is always ready and
// writes take effect at once; they should be issued only while no event is
// in flight. The fail-safe trip clears only on reset.
module heartbeat_fault_supervisor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Event channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  hbfs_pkg::t_event                i_event,
    // Status channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output hbfs_pkg::t_status               o_status,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hbfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import hbfs_pkg::*;

    // Configuration registers.
    logic [31:0] r_fail_safe_timeout;
    logic [31:0] r_degraded_timeout;
    logic [7:0]  r_crc_limit;
    logic [7:0]  r_auth_limit;

    // Supervisor state.
    logic [31:0] r_last_hb, n_last_hb;
    logic [7:0]  r_missed, n_missed;
    logic        r_degraded, n_degraded;
    logic        r_trip, n_trip;
    logic [7:0]  r_crc_tally, n_crc_tally;
    logic [7:0]  r_auth_tally, n_auth_tally;

    // Pipeline registers.
    logic        r_in_valid;
    t_event      r_in;
    logic        r_out_valid;
    t_status     r_out;

    logic        advance;
    logic        fire;
    logic [31:0] elapsed;
    logic [PROD_W-1:0] prod;
    logic [7:0]  seconds;
    logic [7:0]  crc_inc;
    logic [7:0]  auth_inc;
    t_status     n_status;

    // The output register moves when it is empty or its word is taken; the
    // input register holds while the output side is blocked.
    assign advance     = !r_out_valid || !i_stall;
    assign fire        = r_in_valid && advance;
    assign o_stall     = r_in_valid && !advance;
    assign o_valid     = r_out_valid;
    assign o_status    = r_out;
    assign o_cfg_ready = 1'b1;

    // Elapsed time since the last heartbeat wraps at 32 bits. Past the
    // saturation point the seconds count is pinned; below it the quotient
    // by 1000 comes from the reciprocal multiply.
    assign elapsed  = r_in.now_ms - r_last_hb;
    assign prod     = PROD_W'(elapsed[ELAPSED_W-1:0]) * PROD_W'(RECIP);
    assign seconds  = (elapsed >= SAT_ELAPSED) ? MISSED_MAX : prod[RECIP_SHIFT +: 8];

    assign crc_inc  = (r_crc_tally == MISSED_MAX) ? r_crc_tally : r_crc_tally + 8'd1;
    assign auth_inc = (r_auth_tally == MISSED_MAX) ? r_auth_tally : r_auth_tally + 8'd1;

    always_comb begin
        n_last_hb    = r_last_hb;
        n_missed     = r_missed;
        n_degraded   = r_degraded;
        n_trip       = r_trip;
        n_crc_tally  = r_crc_tally;
        n_auth_tally = r_auth_tally;
        if (fire) begin
            case (r_in.mode)
                MODE_CHECK: begin
                    // A tripped supervisor ignores checks. A stored time of
                    // zero means the clock has not started yet.
                    if (!r_trip) begin
                        if (r_last_hb == 32'd0) begin
                            n_last_hb = r_in.now_ms;
                        end else if (elapsed >= r_fail_safe_timeout) begin
                            n_missed   = seconds;
                            n_trip     = 1'b1;
                            n_degraded = 1'b1;
                        end else if (elapsed >= r_degraded_timeout) begin
                            n_missed   = seconds;
                            n_degraded = 1'b1;
                        end else begin
                            n_degraded = 1'b0;
                        end
                    end
                end
                MODE_HEARTBEAT: begin
                    // Applies even when tripped; the trip itself stays.
                    n_last_hb  = r_in.now_ms;
                    n_missed   = 8'd0;
                    n_degraded = 1'b0;
                end
                MODE_CRC_ERR: begin
                    if (!r_trip) begin
                        n_crc_tally = crc_inc;
                        if (crc_inc >= r_crc_limit) begin
                            n_trip     = 1'b1;
                            n_degraded = 1'b1;
                        end
                    end
                end
                MODE_AUTH_FAIL: begin
                    if (!r_trip) begin
                        n_auth_tally = auth_inc;
                        if (auth_inc >= r_auth_limit) begin
                            n_trip     = 1'b1;
                            n_degraded = 1'b1;
                        end
                    end
                end
                MODE_FAULT: begin
                    n_trip     = 1'b1;
                    n_degraded = 1'b1;
                end
                default: begin
                    // Unused event codes leave the state as it is.
                end
            endcase
        end
    end

    always_comb begin
        n_status.fail_safe_active = n_trip;
        n_status.degraded_mode    = n_degraded;
        n_status.missed_seconds   = n_missed;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_safe_timeout <= FAIL_SAFE_TIMEOUT_RST;
            r_degraded_timeout  <= DEGRADED_TIMEOUT_RST;
            r_crc_limit         <= CRC_LIMIT_RST;
            r_auth_limit        <= AUTH_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FAIL_SAFE_TIMEOUT: r_fail_safe_timeout <= i_cfg_data;
                REG_DEGRADED_TIMEOUT:  r_degraded_timeout  <= i_cfg_data;
                REG_CRC_LIMIT:         r_crc_limit         <= i_cfg_data[7:0];
                REG_AUTH_LIMIT:        r_auth_limit        <= i_cfg_data[7:0];
                default: begin
                    // Writes to other indexes are dropped.
                end
            endcase
        end
    end

    // Supervisor state and pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hb    <= 32'd0;
            r_missed     <= 8'd0;
            r_degraded   <= 1'b0;
            r_trip       <= 1'b0;
            r_crc_tally  <= 8'd0;
            r_auth_tally <= 8'd0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_last_hb    <= n_last_hb;
            r_missed     <= n_missed;
            r_degraded   <= n_degraded;
            r_trip       <= n_trip;
            r_crc_tally  <= n_crc_tally;
            r_auth_tally <= n_auth_tally;
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_event;
        end
        if (fire) begin
            r_out <= n_status;
        end
    end

    // The trip is sticky until reset.
    a_trip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trip |=> r_trip)
        else $error("fail-safe trip cleared without reset");

    // Error tallies never count down.
    a_tally_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_crc_tally >= $past(r_crc_tally)) &&
                 (r_auth_tally >= $past(r_auth_tally)))
        else $error("error tally decreased");

    // An event held in the input register is not lost while the output waits.
    a_hold_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid && $stable(r_in))
        else $error("stalled event dropped or changed");

    // A heartbeat reports a clear degraded flag and zero missed seconds.
    a_heartbeat_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.mode == MODE_HEARTBEAT) |=>
            (o_valid && !o_status.degraded_mode && o_status.missed_seconds == 8'd0))
        else $error("heartbeat status not cleared");

    // An event that newly latches the trip also sets degraded.
    a_trip_degraded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_trip && n_trip) |-> n_degraded)
        else $error("trip reported without degraded");

endmodule

/* tb/heartbeat_fault_supervisor_unit_tb.sv */
// Self-checking testbench for heartbeat_fault_supervisor_unit: drives event
// words and register writes, mirrors the supervisor state and checks each
// status word in order. Depends on hbfs_pkg and the supervisor top level.
module heartbeat_fault_supervisor_unit_tb;
    import hbfs_pkg::*;

    // Mode codes that the supervisor treats as no-ops.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    // A register index with nothing behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd200;

    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 170;
    localparam int unsigned TAIL_ITEMS    = 80;
    localparam int unsigned LIMIT_TIME    = 4_000_000;

    // Ways the single fail-safe trip of the run can be reached.
    typedef enum int unsigned {
        TRIP_BY_TIMEOUT,
        TRIP_BY_CRC,
        TRIP_BY_AUTH,
        TRIP_BY_FAULT
    } trip_cause_e;

    // Mirror of the supervisor: its own copy of the registers and state, and
    // the queue of status words that accepted events still owe.
    class supervisor_mirror;
        logic [31:0] fail_safe_ms;
        logic [31:0] degraded_ms;
        logic [7:0]  crc_limit;
        logic [7:0]  auth_limit;
        logic [31:0] last_beat;
        logic [7:0]  missed_secs;
        logic [7:0]  crc_tally;
        logic [7:0]  auth_tally;
        logic        degraded;
        logic        tripped;
        t_status     status_due[$];
        int          mismatches;

        function new();
            fail_safe_ms = FAIL_SAFE_TIMEOUT_RST;
            degraded_ms  = DEGRADED_TIMEOUT_RST;
            crc_limit    = CRC_LIMIT_RST;
            auth_limit   = AUTH_LIMIT_RST;
            last_beat    = '0;
            missed_secs  = '0;
            crc_tally    = '0;
            auth_tally   = '0;
            degraded     = 1'b0;
            tripped      = 1'b0;
            mismatches   = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
            case (idx)
                REG_FAIL_SAFE_TIMEOUT: fail_safe_ms = data;
                REG_DEGRADED_TIMEOUT:  degraded_ms  = data;
                REG_CRC_LIMIT:         crc_limit    = data[7:0];
                REG_AUTH_LIMIT:        auth_limit   = data[7:0];
                default: ;
            endcase
        endfunction

        function void latch_trip();
            tripped  = 1'b1;
            degraded = 1'b1;
        endfunction

        function logic [7:0] whole_seconds(input logic [31:0] elapsed);
            logic [31:0] secs;
            secs = elapsed / MS_PER_SECOND;
            return (secs < 32'(MISSED_MAX)) ? secs[7:0] : MISSED_MAX;
        endfunction

        // Applies one accepted event and queues the status it produces.
        function void note_event(input t_event ev);
            logic [31:0] elapsed;
            t_status     st;
            case (ev.mode)
                MODE_CHECK: begin
                    if (!tripped) begin
                        if (last_beat == '0) begin
                            last_beat = ev.now_ms;
                        end else begin
                            elapsed = ev.now_ms - last_beat;
                            if (elapsed >= fail_safe_ms) begin
                                missed_secs = whole_seconds(elapsed);
                                latch_trip();
                            end else if (elapsed >= degraded_ms) begin
                                missed_secs = whole_seconds(elapsed);
                                degraded    = 1'b1;
                            end else begin
                                degraded = 1'b0;
                            end
                        end
                    end
                end
                MODE_HEARTBEAT: begin
                    last_beat   = ev.now_ms;
                    missed_secs = '0;
                    degraded    = 1'b0;
                end
                MODE_CRC_ERR: begin
                    if (!tripped) begin
                        if (crc_tally != 8'hFF) crc_tally++;
                        if (crc_tally >= crc_limit) latch_trip();
                    end
                end
                MODE_AUTH_FAIL: begin
                    if (!tripped) begin
                        if (auth_tally != 8'hFF) auth_tally++;
                        if (auth_tally >= auth_limit) latch_trip();
                    end
                end
                MODE_FAULT: latch_trip();
                default: ;
            endcase
            st.fail_safe_active = tripped;
            st.degraded_mode    = degraded;
            st.missed_seconds   = missed_secs;
            status_due.push_back(st);
        endfunction

        // Compares one delivered status word with the oldest one owed.
        function void check_status(input t_status got);
            t_status want;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("status word %h arrived with none owed", got);
                return;
            end
            want = status_due.pop_front();
            if (got.fail_safe_active !== want.fail_safe_active ||
                got.degraded_mode !== want.degraded_mode ||
                got.missed_seconds !== want.missed_seconds) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("status mismatch: want trip=%0d degr=%0d secs=%0d, got %0d %0d %0d",
                             want.fail_safe_active, want.degraded_mode, want.missed_seconds,
                             got.fail_safe_active, got.degraded_mode, got.missed_seconds);
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    t_event     i_event     = '0;
    logic       i_stall     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic       o_stall;
    logic       o_valid;
    t_status    o_status;
    logic       o_cfg_ready;

    supervisor_mirror sb = new();

    // Percent chance per cycle (receiver) or per word (sender) that an idle
    // burst starts. The closing part of the run sets calm and never idles.
    int unsigned idle_pct   = 25;
    bit          calm       = 1'b0;
    int unsigned stall_left = 0;

    heartbeat_fault_supervisor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_event     (i_event),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Status side. Values read right after the edge are the ones that the
    // edge sampled, so a word counts as taken when o_valid was high and our
    // stall was low. The stall itself comes in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_status(o_status);
        if (calm || idle_pct == 0) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 10) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic t_event make_event(input logic [2:0] mode, input logic [31:0] now);
        t_event ev;
        ev.mode   = mode;
        ev.now_ms = now;
        return ev;
    endfunction

    // Presents one event word and returns in the cycle it is accepted.
    // Valid is only lowered for an idle burst, so back-to-back words keep it
    // high without a drop inside one time step.
    task automatic send_event(input logic [2:0] mode, input logic [31:0] now);
        t_event ev;
        ev = make_event(mode, now);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_event <= ev;
        do @(posedge i_clk); while (o_stall);
        sb.note_event(ev);
    endtask

    // Lets every owed status word come back and the pipeline empty out.
    task automatic drain_events();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with nothing in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain_events();
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Elapsed times spread over short gaps, the degraded edge, the
    // saturation edge of the seconds count and the whole 32-bit range.
    function automatic logic [31:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 4000);
            4, 5:       return $urandom_range(0, 400000);
            6:          return $urandom;
            7:          return sb.degraded_ms + $urandom_range(0, 2) - 1;
            8:          return $urandom_range(254000, 256999);
            default:    return $urandom_range(0, 999);
        endcase
    endfunction

    // One random event. Most are heartbeats and checks timed against the
    // last heartbeat; errors and spare codes are mixed in. Without
    // allow_trip the tallies stay under their limits, no fault is sent and
    // no check reaches the fail-safe limit, so the trip stays clear.
    task automatic random_event(input bit allow_trip);
        logic [31:0] el;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        el = pick_elapsed();
        if (!allow_trip && el >= sb.fail_safe_ms)
            el = sb.fail_safe_ms - 1;
        if (pick < 15) begin
            send_event(MODE_HEARTBEAT, ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom);
        end else if (pick < 80) begin
            send_event(MODE_CHECK, sb.last_beat + el);
        end else if (pick < 85 && (allow_trip || sb.crc_tally < 8'd250)) begin
            send_event(MODE_CRC_ERR, $urandom);
        end else if (pick >= 85 && pick < 90 && (allow_trip || sb.auth_tally < 8'd250)) begin
            send_event(MODE_AUTH_FAIL, $urandom);
        end else if (pick >= 90 && pick < 95) begin
            send_event(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), $urandom);
        end else if (allow_trip) begin
            send_event(MODE_FAULT, $urandom);
        end else begin
            send_event(MODE_HEARTBEAT, sb.last_beat + $urandom_range(1, 3000));
        end
    endtask

    initial begin
        logic [31:0] degraded_set[6];
        logic [31:0] beat_at;
        logic [31:0] limit;
        trip_cause_e cause;

        degraded_set = '{32'd0, 32'd1, 32'd2000, 32'd65535, 32'd300000, 32'hFFFF_FFFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening with the reset register values (trip at 5000 ms,
        // degraded at 2000 ms, CRC limit 10, auth limit 3).
        send_event(MODE_CHECK, 32'd0);           // stores zero: clock still unstarted
        send_event(MODE_CHECK, 32'd1000);        // starts the clock
        send_event(MODE_CHECK, 32'd2500);        // under the degraded limit
        send_event(MODE_CHECK, 32'd3000);        // exactly at the degraded limit
        send_event(MODE_CHECK, 32'd5999);        // one below the fail-safe limit
        send_event(MODE_HEARTBEAT, 32'd6000);
        send_event(MODE_SPARE_LO, 32'hFFFF_FFFF);
        send_event(3'd6, 32'h5555_AAAA);
        send_event(MODE_SPARE_HI, 32'hAAAA_5555);
        send_event(MODE_CRC_ERR, 32'd0);
        send_event(MODE_AUTH_FAIL, 32'd0);
        send_event(MODE_AUTH_FAIL, 32'd0);       // one short of the auth limit
        send_event(MODE_HEARTBEAT, 32'd0);       // a heartbeat at zero unstarts the clock
        send_event(MODE_CHECK, 32'hFFFF_FF00);
        send_event(MODE_CHECK, 32'h0000_0700);   // elapsed wraps past zero
        send_event(MODE_HEARTBEAT, 32'hFFFF_FFFF);
        send_event(MODE_CHECK, 32'h0000_07CF);   // wrapped, exactly at the limit
        send_event(MODE_HEARTBEAT, 32'd100);
        send_event(MODE_CHECK, 32'd100);         // zero elapsed

        // Widest limits so that the long random part never trips.
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        write_reg(REG_FAIL_SAFE_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(REG_DEGRADED_TIMEOUT, 32'd1000);
        write_reg(REG_CRC_LIMIT, 32'd255);
        write_reg(REG_AUTH_LIMIT, 32'd255);
        send_event(MODE_CHECK, 32'd100 + 32'd255000);   // seconds count just saturates
        send_event(MODE_CHECK, 32'd100 + 32'd254999);   // one below saturation
        send_event(MODE_CHECK, 32'd100 + 32'hFFFF_FFFE); // largest elapsed short of a trip

        // Random phases, each under its own degraded limit. One phase runs
        // with no idling on either side.
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_DEGRADED_TIMEOUT, degraded_set[p]);
            idle_pct = (p == 3) ? 0 : 25;
            repeat (PHASE_ITEMS) random_event(1'b0);
        end

        // Closing part: no idling. The one trip of the run is reached by a
        // randomly chosen route, then the latched behavior is exercised.
        calm     = 1'b1;
        idle_pct = 0;
        cause    = trip_cause_e'($urandom_range(0, 3));
        limit    = 32'd0;
        case (cause)
            TRIP_BY_TIMEOUT: begin
                case ($urandom_range(0, 2))
                    0:       limit = 32'd0;
                    1:       limit = 32'd1;
                    default: limit = $urandom_range(2, 300000);
                endcase
                write_reg(REG_FAIL_SAFE_TIMEOUT, limit);
                write_reg(REG_DEGRADED_TIMEOUT, $urandom_range(0, 3000));
            end
            TRIP_BY_CRC:  write_reg(REG_CRC_LIMIT, $urandom_range(0, sb.crc_tally + 1));
            TRIP_BY_AUTH: write_reg(REG_AUTH_LIMIT, $urandom_range(0, sb.auth_tally + 1));
            default: ;
        endcase
        beat_at = $urandom_range(1, 32'hFFFF_0000);
        send_event(MODE_HEARTBEAT, beat_at);
        case (cause)
            TRIP_BY_TIMEOUT: send_event(MODE_CHECK, beat_at + limit + $urandom_range(0, 5000));
            TRIP_BY_CRC:     send_event(MODE_CRC_ERR, $urandom);
            TRIP_BY_AUTH:    send_event(MODE_AUTH_FAIL, $urandom);
            default:         send_event(MODE_FAULT, $urandom);
        endcase
        repeat (TAIL_ITEMS) random_event(1'b1);

        drain_events();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("heartbeat_fault_supervisor_unit_tb: clean");
        else
            $display("heartbeat_fault_supervisor_unit_tb: errors");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(LIMIT_TIME);
        $display("heartbeat_fault_supervisor_unit_tb: errors");
        $finish;
    end

endmodule
